// ----- sv/hmfb_pkg.sv -----
// Shared constants and codes for the height map hole fill and border block.
package hmfb_pkg;

  localparam int ROW_LEN_W              = 12;
  localparam int THRESH_W               = 23;
  localparam int CFG_DATA_W             = 23;
  localparam int CFG_INDEX_W            = 1;
  localparam int CLASS_W                = 2;
  localparam int NB_COUNT               = 8;
  localparam int MIN_ROW_LENGTH         = 3;
  localparam int ROW_LENGTH_RESET       = 2048;
  localparam int BORDER_THRESHOLD_RESET = 2560;

  // row and pad bookkeeping limits
  localparam int ROWS_SEEN_MAX   = 3;
  localparam int PAD_ROWS_MAX    = 4;
  localparam int FILL_PAD_LIMIT  = 2;
  localparam int EMIT_PAD_LIMIT  = 3;

  localparam logic REQ_PAD = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_LENGTH       = 1'b0,
    REG_BORDER_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef enum logic [CLASS_W-1:0] {
    CLS_FLAT    = 2'd0,
    CLS_BORDER  = 2'd1,
    CLS_NO_DATA = 2'd2
  } border_class_t;

endpackage

// ----- sv/hmfb_sample_if.sv -----
// Input sample channel: valid/ready with one height sample.
interface hmfb_sample_if #(
  parameter int HEIGHT_WIDTH = 24
);
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic                    start_of_frame;
  logic                    sample_present;
  logic [HEIGHT_WIDTH-1:0] sample_height;

  modport source (output valid, req_type, start_of_frame, sample_present, sample_height,
                  input ready);
  modport sink   (input valid, req_type, start_of_frame, sample_present, sample_height,
                  output ready);
endinterface

// ----- sv/hmfb_pixel_if.sv -----
// Output pixel channel: valid/ready with one filled, classified pixel.
interface hmfb_pixel_if #(
  parameter int HEIGHT_WIDTH = 24
);
  import hmfb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [HEIGHT_WIDTH-1:0] out_height;
  logic                    out_present;
  logic [CLASS_W-1:0]      border_class;
  logic                    end_of_row;

  modport source (output valid, out_height, out_present, border_class, end_of_row,
                  input ready);
  modport sink   (input valid, out_height, out_present, border_class, end_of_row,
                  output ready);
endinterface

// ----- sv/height_map_hole_fill_and_border_core.sv -----
// Top level: streaming height map hole fill and border classification.
// Latency: a pixel leaves two rows and one column after its sample is taken.
// Each sample runs the load, post and emit states, plus a write state on a row's
//   last column; samples are taken only in idle. A fill waits in the shared fill
//   unit, twice on the last column; a full output register stalls.
// Reset (rst, synchronous): counters, bank rotation and row-valid flags clear;
//   row_length = 2048, border_threshold = 2560; the stores are not cleared.
module height_map_hole_fill_and_border_core #(
  parameter int MAX_ROW_LENGTH = 2048,
  parameter int HEIGHT_WIDTH   = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  hmfb_sample_if.sink                      samples,
  hmfb_pixel_if.source                     pixels,
  input  logic                             cfg_we,
  input  logic [hmfb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hmfb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hmfb_pkg::*;

  localparam int W      = HEIGHT_WIDTH;
  localparam int CW     = $clog2(MAX_ROW_LENGTH);
  localparam int DIFF_W = W + 1;
  localparam int CMP_W  = (DIFF_W > THRESH_W) ? DIFF_W : THRESH_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_FILL1 = 7'b0000100,
    S_POST1 = 7'b0001000,
    S_FILL2 = 7'b0010000,
    S_WR2   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } core_state_t;

  core_state_t state;

  // configuration
  logic [ROW_LEN_W-1:0] row_length;
  logic [THRESH_W-1:0]  border_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length       <= ROW_LEN_W'(ROW_LENGTH_RESET);
      border_threshold <= THRESH_W'(BORDER_THRESHOLD_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_LENGTH:       row_length       <= cfg_data[ROW_LEN_W-1:0];
        REG_BORDER_THRESHOLD: border_threshold <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // row length in use, clamped
  logic [CW:0] l_len;
  always_comb begin
    if (row_length < ROW_LEN_W'(MIN_ROW_LENGTH)) begin
      l_len = (CW+1)'(MIN_ROW_LENGTH);
    end else if (int'(row_length) > MAX_ROW_LENGTH) begin
      l_len = (CW+1)'(MAX_ROW_LENGTH);
    end else begin
      l_len = (CW+1)'(row_length);
    end
  end

  // frame position
  logic [CW-1:0] column_count;
  logic [1:0]    rows_seen;
  logic [2:0]    pad_rows;
  logic          draining;

  // item being worked on
  logic [CW-1:0] cur_col;
  logic [1:0]    cur_rows;
  logic [2:0]    cur_pad;
  logic [W:0]    smp;

  // Row banks: three memories rotate through the roles of the row being filled,
  // the last complete row and the row above it. A flag marks a role whose row
  // is empty (early in a frame), so stale bank contents read as absent.
  logic [1:0] fa_sel, bc_sel, ba_sel;
  logic       bc_zero, ba_zero;

  // Sliding window over column c-1 and c-2, kept in registers so each item
  // needs only one read per memory at column c.
  logic [W:0] bcm1, bcm2, bam1, fam1, fam2, osm1, osm2;
  logic [W:0] bc_c_q, ba_c_q, fa_c_q, f1res, f2res;

  // accept path
  logic          acc, is_real, restart;
  logic [CW-1:0] col_now;
  logic [1:0]    rows_now;
  logic [2:0]    pad_base, pad_now;
  logic [CW:0]   col_inc;
  logic          wrap;

  assign samples.ready = (state == S_IDLE);
  assign acc      = samples.valid && samples.ready;
  assign is_real  = (samples.req_type != REQ_PAD);
  assign restart  = is_real && (samples.start_of_frame || draining);
  assign col_now  = restart ? '0 : column_count;
  assign rows_now = restart ? '0 : rows_seen;
  assign pad_base = restart ? '0 : pad_rows;
  assign pad_now  = (col_now == '0 && !is_real && pad_base < 3'(PAD_ROWS_MAX))
                    ? pad_base + 3'd1 : pad_base;
  assign col_inc  = {1'b0, col_now} + (CW+1)'(1);
  assign wrap     = (col_inc >= l_len);

  // memories
  logic [W:0]    os_mem [MAX_ROW_LENGTH];
  logic [W:0]    os_rdata;
  logic          os_we;
  logic [W:0]    bank_rdata [3];
  logic          bank_we;
  logic [CW-1:0] bank_waddr;
  logic [W:0]    bank_wdata;

  always_ff @(posedge clk) begin
    if (os_we) os_mem[cur_col] <= smp;
    if (acc) os_rdata <= os_mem[col_now];
  end

  for (genvar g = 0; g < 3; g++) begin : g_bank
    logic [W:0] mem [MAX_ROW_LENGTH];
    always_ff @(posedge clk) begin
      if (bank_we && fa_sel == 2'(g)) mem[bank_waddr] <= bank_wdata;
      if (acc) bank_rdata[g] <= mem[col_now];
    end
  end

  // read data as seen by the current item
  logic [W:0] bc_live, ba_live, fa_live;
  assign bc_live = bc_zero ? '0 : bank_rdata[bc_sel];
  assign ba_live = ba_zero ? '0 : bank_rdata[ba_sel];
  assign fa_live = (cur_rows != 2'd0) ? os_rdata : '0;

  logic c_ge1, c_ge2, c0, last_col, fill_en;
  assign c_ge1    = (cur_col != '0);
  assign c_ge2    = (cur_col > CW'(1));
  assign c0       = !c_ge1;
  assign last_col = ({1'b0, cur_col} == l_len - (CW+1)'(1));
  assign fill_en  = (cur_rows != 2'd0) && (cur_pad < 3'(FILL_PAD_LIMIT));

  // fill unit hookup: 8-neighbour set for column c-1, 5-neighbour set for
  // the last column
  logic       fill_start, fill_done;
  logic [W:0] fill_nb [NB_COUNT];
  logic [W:0] fill_result;

  always_comb begin
    if (state == S_POST1) begin
      fill_nb[0] = bcm1;
      fill_nb[1] = bc_c_q;
      fill_nb[2] = f1res;
      fill_nb[3] = osm1;
      fill_nb[4] = smp;
      fill_nb[5] = '0;
      fill_nb[6] = '0;
      fill_nb[7] = '0;
    end else begin
      fill_nb[0] = c_ge2 ? bcm2 : '0;
      fill_nb[1] = bcm1;
      fill_nb[2] = bc_live;
      fill_nb[3] = c_ge2 ? fam2 : '0;
      fill_nb[4] = fa_live;
      fill_nb[5] = c_ge2 ? osm2 : '0;
      fill_nb[6] = osm1;
      fill_nb[7] = smp;
    end
  end

  assign fill_start = ((state == S_LOAD) && c_ge1 && fill_en && !fam1[W]) ||
                      ((state == S_POST1) && last_col && fill_en && !fa_c_q[W]);

  hmfb_fill #(
    .HEIGHT_WIDTH(HEIGHT_WIDTH)
  ) u_fill (
    .clk    (clk),
    .rst    (rst),
    .start  (fill_start),
    .nb     (fill_nb),
    .done   (fill_done),
    .result (fill_result)
  );

  assign os_we      = (state == S_LOAD);
  assign bank_we    = ((state == S_POST1) && c_ge1) || (state == S_WR2);
  assign bank_waddr = (state == S_POST1) ? CW'(cur_col - CW'(1)) : cur_col;
  assign bank_wdata = (state == S_POST1) ? f1res : f2res;

  // border classification of the pixel leaving this item
  logic       emit_need;
  logic [W:0] e_ctr;
  logic [W:0] e_nb [4];
  logic       e_border;
  logic signed [DIFF_W-1:0] e_diff;
  logic [DIFF_W-1:0]        e_abs;

  assign emit_need = c0 ? (cur_rows == 2'(ROWS_SEEN_MAX) && cur_pad < 3'(PAD_ROWS_MAX))
                        : (cur_rows >= 2'd2 && cur_pad < 3'(EMIT_PAD_LIMIT));
  assign e_ctr   = bcm1;
  assign e_nb[0] = bam1;
  assign e_nb[1] = c0 ? fam1 : f1res;
  assign e_nb[2] = (c0 || c_ge2) ? bcm2 : '0;
  assign e_nb[3] = c0 ? '0 : bc_c_q;

  always_comb begin
    e_border = 1'b0;
    e_diff   = '0;
    e_abs    = '0;
    for (int i = 0; i < 4; i++) begin
      e_diff = DIFF_W'($signed(e_nb[i][W-1:0])) - DIFF_W'($signed(e_ctr[W-1:0]));
      e_abs  = e_diff[DIFF_W-1] ? DIFF_W'(-e_diff) : DIFF_W'(e_diff);
      if (e_nb[i][W] && (CMP_W'(e_abs) > CMP_W'(border_threshold))) e_border = 1'b1;
    end
  end

  // output register
  logic                out_valid;
  logic [W-1:0]        out_height;
  logic                out_present;
  border_class_t       out_class;
  logic                out_eor;
  logic                out_load;

  assign out_load = (state == S_EMIT) && emit_need && (!out_valid || pixels.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pixels.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_height  <= e_ctr[W] ? e_ctr[W-1:0] : '0;
      out_present <= e_ctr[W];
      out_class   <= !e_ctr[W] ? CLS_NO_DATA : (e_border ? CLS_BORDER : CLS_FLAT);
      out_eor     <= c0;
    end
  end

  assign pixels.valid        = out_valid;
  assign pixels.out_height   = out_height;
  assign pixels.out_present  = out_present;
  assign pixels.border_class = out_class;
  assign pixels.end_of_row   = out_eor;

  // control sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      column_count <= '0;
      rows_seen    <= '0;
      pad_rows     <= '0;
      draining     <= 1'b0;
      fa_sel       <= 2'd0;
      bc_sel       <= 2'd1;
      ba_sel       <= 2'd2;
      bc_zero      <= 1'b1;
      ba_zero      <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            column_count <= wrap ? '0 : col_inc[CW-1:0];
            rows_seen    <= (wrap && rows_now < 2'(ROWS_SEEN_MAX)) ? rows_now + 2'd1
                                                                   : rows_now;
            pad_rows     <= pad_now;
            draining     <= !is_real || (draining && !restart);
            cur_col      <= col_now;
            cur_rows     <= rows_now;
            cur_pad      <= pad_now;
            smp          <= (is_real && samples.sample_present)
                            ? {1'b1, samples.sample_height} : '0;
            // new row: rotate bank roles
            if (col_now == '0) begin
              fa_sel  <= ba_sel;
              bc_sel  <= fa_sel;
              ba_sel  <= bc_sel;
              bc_zero <= (rows_now < 2'd2);
              ba_zero <= (rows_now < 2'(ROWS_SEEN_MAX));
            end
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          bc_c_q <= bc_live;
          ba_c_q <= ba_live;
          fa_c_q <= fa_live;
          if (fill_start) begin
            state <= S_FILL1;
          end else begin
            f1res <= fam1;
            state <= S_POST1;
          end
        end
        S_FILL1: begin
          if (fill_done) begin
            f1res <= fill_result;
            state <= S_POST1;
          end
        end
        S_POST1: begin
          if (!last_col) begin
            state <= S_EMIT;
          end else if (fill_start) begin
            state <= S_FILL2;
          end else begin
            f2res <= fa_c_q;
            state <= S_WR2;
          end
        end
        S_FILL2: begin
          if (fill_done) begin
            f2res <= fill_result;
            state <= S_WR2;
          end
        end
        S_WR2: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!emit_need || !out_valid || pixels.ready) begin
            bcm2  <= bcm1;
            bcm1  <= bc_c_q;
            bam1  <= ba_c_q;
            fam2  <= f1res;
            fam1  <= last_col ? f2res : fa_c_q;
            osm2  <= osm1;
            osm1  <= smp;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/hmfb_fill.sv -----
// Multi-cycle hole fill unit: neighbour mean, majority split, rounded group mean.
module hmfb_fill #(
  parameter int HEIGHT_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [HEIGHT_WIDTH:0] nb [hmfb_pkg::NB_COUNT],
  output logic                  done,
  output logic [HEIGHT_WIDTH:0] result
);
  import hmfb_pkg::*;

  localparam int W         = HEIGHT_WIDTH;
  localparam int SUM_W     = W + 4;
  localparam int PROD_W    = W + 5;
  localparam int X_W       = W + 5;
  localparam int DIV_W     = ((X_W + 3) / 4) * 4;
  localparam int DIV_STEPS = DIV_W / 4;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  typedef enum logic [5:0] {
    F_IDLE  = 6'b000001,
    F_SUM   = 6'b000010,
    F_SPLIT = 6'b000100,
    F_PREP  = 6'b001000,
    F_DIV   = 6'b010000,
    F_DONE  = 6'b100000
  } fill_state_t;

  fill_state_t state;

  logic [W:0]               nb_q [NB_COUNT];
  logic signed [SUM_W-1:0]  sum_q, hs_q, ls_q;
  logic [3:0]               cnt_q, hc_q, lc_q;
  logic                     neg_q, empty_q;
  logic [4:0]               d_q;
  logic [DIV_W-1:0]         u_q, quo_q;
  logic [4:0]               rem_q;
  logic [STEP_W-1:0]        step_q;

  // neighbour sum and count
  logic signed [SUM_W-1:0] sum_c;
  logic [3:0]              cnt_c;
  always_comb begin
    sum_c = '0;
    cnt_c = '0;
    for (int i = 0; i < NB_COUNT; i++) begin
      if (nb_q[i][W]) begin
        sum_c = sum_c + SUM_W'($signed(nb_q[i][W-1:0]));
        cnt_c = cnt_c + 4'd1;
      end
    end
  end

  // split around the mean: v*cnt > sum goes high
  logic signed [SUM_W-1:0]  hs_c, ls_c;
  logic [3:0]               hc_c, lc_c;
  logic signed [PROD_W-1:0] prod_c;
  always_comb begin
    hs_c   = '0;
    ls_c   = '0;
    hc_c   = '0;
    lc_c   = '0;
    prod_c = '0;
    for (int i = 0; i < NB_COUNT; i++) begin
      prod_c = PROD_W'($signed(nb_q[i][W-1:0])) * PROD_W'($signed({1'b0, cnt_q}));
      if (nb_q[i][W]) begin
        if (prod_c > PROD_W'(sum_q)) begin
          hs_c = hs_c + SUM_W'($signed(nb_q[i][W-1:0]));
          hc_c = hc_c + 4'd1;
        end else begin
          ls_c = ls_c + SUM_W'($signed(nb_q[i][W-1:0]));
          lc_c = lc_c + 4'd1;
        end
      end
    end
  end

  // dividend 2*gs+gc over divisor 2*gc; negative dividends biased for floor
  logic signed [SUM_W-1:0] gs_c;
  logic [3:0]              gc_c;
  logic signed [X_W-1:0]   x_c;
  logic [4:0]              d_c;
  logic [X_W-1:0]          ux_c;
  always_comb begin
    gs_c = (hc_q > lc_q) ? hs_q : ls_q;
    gc_c = (hc_q > lc_q) ? hc_q : lc_q;
    d_c  = {gc_c, 1'b0};
    x_c  = (X_W'(gs_c) <<< 1) + X_W'($signed({1'b0, gc_c}));
    if (x_c[X_W-1]) begin
      ux_c = X_W'(-x_c + X_W'($signed({1'b0, d_c})) - X_W'(1));
    end else begin
      ux_c = x_c;
    end
  end

  // four quotient bits per cycle
  logic [DIV_W-1:0] u_n, quo_n;
  logic [4:0]       rem_n;
  logic [5:0]       trial;
  always_comb begin
    u_n   = u_q;
    quo_n = quo_q;
    rem_n = rem_q;
    trial = '0;
    for (int j = 0; j < 4; j++) begin
      trial = {rem_n, u_n[DIV_W-1]};
      u_n   = u_n << 1;
      if (trial >= {1'b0, d_q}) begin
        trial = trial - {1'b0, d_q};
        quo_n = {quo_n[DIV_W-2:0], 1'b1};
      end else begin
        quo_n = {quo_n[DIV_W-2:0], 1'b0};
      end
      rem_n = trial[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (start) begin
            nb_q  <= nb;
            state <= F_SUM;
          end
        end
        F_SUM: begin
          sum_q <= sum_c;
          cnt_q <= cnt_c;
          state <= F_SPLIT;
        end
        F_SPLIT: begin
          hs_q    <= hs_c;
          ls_q    <= ls_c;
          hc_q    <= hc_c;
          lc_q    <= lc_c;
          empty_q <= (cnt_q == 4'd0);
          state   <= (cnt_q == 4'd0) ? F_DONE : F_PREP;
        end
        F_PREP: begin
          d_q    <= d_c;
          neg_q  <= x_c[X_W-1];
          u_q    <= DIV_W'(ux_c);
          quo_q  <= '0;
          rem_q  <= '0;
          step_q <= '0;
          state  <= F_DIV;
        end
        F_DIV: begin
          u_q    <= u_n;
          quo_q  <= quo_n;
          rem_q  <= rem_n;
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(DIV_STEPS - 1)) state <= F_DONE;
        end
        F_DONE: begin
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  logic [W:0] q_mag, mean;
  assign q_mag  = quo_q[W:0];
  assign mean   = neg_q ? (W+1)'(-q_mag) : q_mag;
  assign done   = (state == F_DONE);
  assign result = empty_q ? '0 : {1'b1, mean[W-1:0]};

endmodule
